[sv/lphc_pkg.sv]
// Shared constants, types and hue helper for the lidar point HSV colorizer.
package lphc_pkg;

	// COLOR_BITS must not exceed RANGE_BITS; RANGE_BITS is at least 8.
	localparam int RANGE_BITS = 20;
	localparam int COLOR_BITS = 8;
	localparam int HUE_BITS   = 8;
	localparam int CMD_W      = 2;

	localparam int NUM_W  = RANGE_BITS + COLOR_BITS;
	localparam int PROD_W = 2 * COLOR_BITS;
	localparam int CNT_W  = $clog2(COLOR_BITS);
	localparam int H6_W   = HUE_BITS + 3;

	localparam int IN_DATA_W  = ((RANGE_BITS + HUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((3 * COLOR_BITS + 7) / 8) * 8;

	localparam logic [COLOR_BITS-1:0] CMAX    = {COLOR_BITS{1'b1}};
	localparam logic [COLOR_BITS-1:0] SAT_FIX =
		COLOR_BITS'((4 * ((1 << COLOR_BITS) - 1) + 2) / 5);

	// hue scale: one sector spans 255 steps of reflectivity * 6
	localparam logic [HUE_BITS-1:0] HUE_MAX  = {HUE_BITS{1'b1}};
	localparam logic [H6_W-1:0]     SPAN1    = H6_W'(255);
	localparam logic [H6_W-1:0]     SPAN2    = H6_W'(510);
	localparam logic [H6_W-1:0]     SPAN3    = H6_W'(765);
	localparam logic [H6_W-1:0]     SPAN4    = H6_W'(1020);
	localparam logic [H6_W-1:0]     SPAN5    = H6_W'(1275);
	localparam logic [H6_W-1:0]     SPAN6    = H6_W'(1530);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_MEASURE  = 2'd1,
		CMD_COLORIZE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VLOAD,
		ST_VDIV,
		ST_CLOAD,
		ST_CDIV,
		ST_XLOAD,
		ST_XDIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [NUM_W-1:0]      num;
		logic [RANGE_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [COLOR_BITS-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		sector_t             sector;
		logic [HUE_BITS-1:0] wgt;
	} hue_t;

	// Split reflectivity into a sector and the weight 255 - |t - 255| for x.
	function automatic hue_t hue_split(input logic [HUE_BITS-1:0] refl);
		logic [H6_W-1:0] h6;
		logic [H6_W-1:0] t;
		logic [H6_W-1:0] fold_off;
		hue_t            res;
		h6 = (H6_W'(refl) << 2) + (H6_W'(refl) << 1);
		if (h6 >= SPAN6)
			t = h6 - SPAN6;
		else if (h6 >= SPAN4)
			t = h6 - SPAN4;
		else if (h6 >= SPAN2)
			t = h6 - SPAN2;
		else
			t = h6;
		fold_off = (t >= SPAN1) ? (t - SPAN1) : (SPAN1 - t);
		res.wgt = HUE_MAX - fold_off[HUE_BITS-1:0];
		if (h6 >= SPAN5)
			res.sector = SEC_MAG_RED;
		else if (h6 >= SPAN4)
			res.sector = SEC_BLU_MAG;
		else if (h6 >= SPAN3)
			res.sector = SEC_CYN_BLU;
		else if (h6 >= SPAN2)
			res.sector = SEC_GRN_CYN;
		else if (h6 >= SPAN1)
			res.sector = SEC_YEL_GRN;
		else
			res.sector = SEC_RED_YEL;
		return res;
	endfunction

endpackage

[sv/lphc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, COLOR_BITS bits.
module lphc_div import lphc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [RANGE_BITS-1:0] rem_q;
	logic [COLOR_BITS-1:0] low_q;
	logic [COLOR_BITS-1:0] quot_q;
	logic [RANGE_BITS-1:0] den_q;

	logic [RANGE_BITS:0]   trial;
	logic [RANGE_BITS:0]   trial_sub;
	logic                  ge;
	logic [RANGE_BITS-1:0] rem_next;

	// partial remainder stays below the divisor, so the trial fits one extra bit
	assign trial     = {rem_q, low_q[COLOR_BITS-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = (trial >= {1'b0, den_q});
	assign rem_next  = ge ? trial_sub[RANGE_BITS-1:0] : trial[RANGE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COLOR_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1:COLOR_BITS];
			low_q <= req.num[COLOR_BITS-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			low_q  <= low_q << 1;
			quot_q <= {quot_q[COLOR_BITS-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

[sv/lidar_point_hsv_colorizer.sv]
// Top level: command handling, max-range register and HSV-to-RGB sequencer.
//
// Each item carries a command in s_tuser. Clear and measure update the held
// maximum range in the cycle the item is accepted and give no result. A
// colorize item keeps s_tready low from its acceptance until the sequencer
// is back in idle, so no other item is taken meanwhile: three rounded
// divisions (value, chroma, hue blend) each run through one shared bit-serial
// divider, and each has a load state, COLOR_BITS quotient bits and a done
// flag; a final output state loads the RGB triple. When the maximum is zero
// or the range reaches it, the value division is skipped. The finished triple
// sits in an output register, so the next item is taken while it waits on
// m_tready; only a second triple finished before the first is taken stalls
// in the output state until m_tready frees the register.
module lidar_point_hsv_colorizer import lphc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // range_mm, reflectivity, zero fill
	input  logic [CMD_W-1:0]      s_tuser,  // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // red, green, blue
);

	state_t state_q, state_next;

	logic [RANGE_BITS-1:0] max_q;
	logic [RANGE_BITS-1:0] diff_q;
	logic                  bypass_q;
	logic [COLOR_BITS-1:0] vbyp_q;
	logic [COLOR_BITS-1:0] v_q;
	logic [COLOR_BITS-1:0] c_q;
	logic [COLOR_BITS-1:0] x_q;
	sector_t               sector_q;
	logic [HUE_BITS-1:0]   wgt_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [RANGE_BITS-1:0] range_in;
	logic [HUE_BITS-1:0]   refl_in;
	logic                  accept;
	hue_t                  hue;

	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic [PROD_W-1:0]         sat_prod;
	logic [COLOR_BITS+HUE_BITS-1:0] hue_prod;
	logic [COLOR_BITS-1:0]     m_val;
	logic [COLOR_BITS-1:0]     red, green, blue;
	logic                      out_load;

	assign range_in = s_tdata[RANGE_BITS-1:0];
	assign refl_in  = s_tdata[RANGE_BITS+HUE_BITS-1:RANGE_BITS];
	assign accept   = s_tvalid && s_tready;
	assign hue      = hue_split(refl_in);

	assign sat_prod = PROD_W'(v_q) * PROD_W'(SAT_FIX);
	assign hue_prod = (COLOR_BITS+HUE_BITS)'(c_q) * (COLOR_BITS+HUE_BITS)'(wgt_q);
	assign m_val    = v_q - c_q;

	lphc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == CMD_COLORIZE)
					state_next = ST_VLOAD;
			end
			ST_VLOAD: begin
				state_next = bypass_q ? ST_CLOAD : ST_VDIV;
			end
			ST_VDIV: begin
				if (div_rsp.done)
					state_next = ST_CLOAD;
			end
			ST_CLOAD: begin
				state_next = ST_CDIV;
			end
			ST_CDIV: begin
				if (div_rsp.done)
					state_next = ST_XLOAD;
			end
			ST_XLOAD: begin
				state_next = ST_XDIV;
			end
			ST_XDIV: begin
				if (div_rsp.done)
					state_next = ST_OUT;
			end
			ST_OUT: begin
				if (out_load)
					state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		out_load      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_VLOAD: begin
				// (max - range) * CMAX + max / 2
				div_req.start = !bypass_q;
				div_req.num   = ({diff_q, {COLOR_BITS{1'b0}}} - NUM_W'(diff_q))
				                + NUM_W'(max_q >> 1);
				div_req.den   = max_q;
			end
			ST_CLOAD: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(sat_prod) + NUM_W'(CMAX >> 1);
				div_req.den   = RANGE_BITS'(CMAX);
			end
			ST_XLOAD: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'(hue_prod) + NUM_W'(HUE_MAX >> 1);
				div_req.den   = RANGE_BITS'(HUE_MAX);
			end
			ST_OUT: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// six-sector table
	always_comb begin
		red   = '0;
		green = '0;
		blue  = '0;
		case (sector_q)
			SEC_RED_YEL: begin
				red   = c_q;
				green = x_q;
			end
			SEC_YEL_GRN: begin
				red   = x_q;
				green = c_q;
			end
			SEC_GRN_CYN: begin
				green = c_q;
				blue  = x_q;
			end
			SEC_CYN_BLU: begin
				green = x_q;
				blue  = c_q;
			end
			SEC_BLU_MAG: begin
				red   = x_q;
				blue  = c_q;
			end
			default: begin
				red   = c_q;
				blue  = x_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				case (s_tuser)
					CMD_CLEAR: begin
						max_q <= '0;
					end
					CMD_MEASURE: begin
						if (range_in > max_q)
							max_q <= range_in;
					end
					default: begin
						max_q <= max_q;
					end
				endcase
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q   <= max_q - range_in;
			bypass_q <= (max_q == '0) || (range_in >= max_q);
			vbyp_q   <= (max_q == '0) ? CMAX : '0;
			sector_q <= hue.sector;
			wgt_q    <= hue.wgt;
		end
		if (state_q == ST_VLOAD && bypass_q)
			v_q <= vbyp_q;
		if (state_q == ST_VDIV && div_rsp.done)
			v_q <= div_rsp.quot;
		if (state_q == ST_CDIV && div_rsp.done)
			c_q <= div_rsp.quot;
		if (state_q == ST_XDIV && div_rsp.done)
			x_q <= div_rsp.quot;
		if (out_load)
			m_tdata_q <= OUT_DATA_W'({blue + m_val, green + m_val, red + m_val});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
